// ===== sv/escaped_crc8_frame_encoder_top_assert.svh =====
`ifndef ESCAPED_CRC8_FRAME_ENCODER_TOP_ASSERT_SVH
`define ESCAPED_CRC8_FRAME_ENCODER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ECFE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ecfe assertion failed");

// next-cycle implication, checked outside reset
`define ECFE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ecfe assertion failed");

`endif

// ===== sv/ecfe_pkg.sv =====
package ecfe_pkg;

	localparam logic [7:0] SEMI_CHAR = 8'h3B;
	localparam logic [7:0] ESC_CHAR = 8'h5C;
	localparam logic [7:0] CRC_TOP_BIT = 8'h80;
	localparam logic [7:0] CRC_POLY_RESET = 8'h07;
	localparam int ECFE_QUEUE_DEPTH = 4;

	// register word indexes on the config port
	localparam logic REG_CRC_POLY = 1'b0;

	// one classified payload byte, as queued between front and back
	typedef struct packed {
		logic [7:0] data;
		logic       esc_data;
		logic       last;
		logic [7:0] crc;
		logic       esc_crc;
	} ecfe_item_t;

	// which wire word of the head item goes out next
	typedef enum logic [2:0] {
		PH_START,
		PH_ESC_DATA,
		PH_DATA,
		PH_ESC_CRC,
		PH_CRC,
		PH_TERM
	} ecfe_phase_t;

	function automatic logic needs_escape(input logic [7:0] b);
		return (b == SEMI_CHAR) || (b == ESC_CHAR);
	endfunction

	// msb-first crc-8 over one byte
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b,
		input logic [7:0] poly);
		logic [7:0] r;
		r = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if ((r & CRC_TOP_BIT) != 8'h00) begin
				r = {r[6:0], 1'b0} ^ poly;
			end else begin
				r = {r[6:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

// ===== sv/ecfe_front.sv =====
module ecfe_front
	import ecfe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic [7:0] crc_poly,
	input  logic       queue_full,
	output logic       push,
	output ecfe_item_t push_item
);

	logic [7:0] crc_q;
	logic [7:0] crc_next;

	assign crc_next = crc8_update(crc_q, data_byte, crc_poly);
	assign in_stall = queue_full;
	assign push = in_valid && !queue_full;

	always_comb begin
		push_item.data = data_byte;
		push_item.esc_data = needs_escape(data_byte);
		push_item.last = last_byte;
		push_item.crc = crc_next;
		push_item.esc_crc = needs_escape(crc_next);
	end

	// running crc, cleared after the last byte of a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= 8'h00;
		end else if (push) begin
			crc_q <= last_byte ? 8'h00 : crc_next;
		end
	end

endmodule

// ===== sv/ecfe_queue.sv =====
module ecfe_queue
	import ecfe_pkg::*;
#(
	parameter int DEPTH = ECFE_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  ecfe_item_t push_item,
	input  logic       pop,
	output logic       full,
	output logic       head_valid,
	output ecfe_item_t head_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ecfe_item_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/ecfe_back.sv =====
`include "escaped_crc8_frame_encoder_top_assert.svh"

module ecfe_back
	import ecfe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  ecfe_item_t head_item,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       frame_end,
	output logic       run_last
);

	ecfe_phase_t ph_q;
	ecfe_phase_t ph_d;
	ecfe_phase_t ph_cur;
	logic        load;
	logic        word_last;
	logic [7:0]  word_byte;
	logic        word_end;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        frame_end_q;
	logic        run_last_q;

	assign load = head_valid && (!out_valid_q || !out_stall);
	assign pop = load && word_last;

	always_comb begin
		ph_cur = ph_q;
		if (ph_q == PH_START) begin
			ph_cur = head_item.esc_data ? PH_ESC_DATA : PH_DATA;
		end
		word_byte = ESC_CHAR;
		word_end = 1'b0;
		word_last = 1'b0;
		ph_d = ph_q;
		case (ph_cur)
			PH_ESC_DATA: begin
				ph_d = PH_DATA;
			end
			PH_DATA: begin
				word_byte = head_item.data;
				word_last = !head_item.last;
				if (head_item.last) begin
					ph_d = head_item.esc_crc ? PH_ESC_CRC : PH_CRC;
				end else begin
					ph_d = PH_START;
				end
			end
			PH_ESC_CRC: begin
				ph_d = PH_CRC;
			end
			PH_CRC: begin
				word_byte = head_item.crc;
				ph_d = PH_TERM;
			end
			PH_TERM: begin
				word_byte = SEMI_CHAR;
				word_end = 1'b1;
				word_last = 1'b1;
				ph_d = PH_START;
			end
			default: begin
				ph_d = PH_START;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_START;
		end else if (load) begin
			ph_q <= ph_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= word_byte;
			frame_end_q <= word_end;
			run_last_q <= word_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign frame_end = frame_end_q;
	assign run_last = run_last_q;

	`ECFE_ASSERT_NOW(a_term_word, out_valid_q && frame_end_q,
		out_byte_q == SEMI_CHAR && run_last_q)
	`ECFE_ASSERT_NOW(a_mid_item_has_head, ph_q != PH_START, head_valid)
	`ECFE_ASSERT_NEXT(a_pop_leaves_run_last, pop, out_valid_q && run_last_q)

endmodule

// ===== sv/escaped_crc8_frame_encoder_top.sv =====
// the first wire word of an item goes via the item queue, then the back end's output register
// throughput: one wire word per cycle unless stalled; an item is 1 word, 2 if escaped, plus 2
//   or 3 crc and terminator words on the last byte, set by the back end's single output register
// the input side takes a word every cycle until the item queue (QUEUE_DEPTH entries) fills
// reset: clears the crc, empties the queue, drops out_valid and sets crc_poly to 0x07
module escaped_crc8_frame_encoder_top
	import ecfe_pkg::*;
#(
	parameter int QUEUE_DEPTH = ECFE_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// payload input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	// encoded wire output
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        frame_end,
	output logic        run_last,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic       [7:0] crc_poly_q;
	logic             cfg_wr;
	logic             push;
	logic             pop;
	logic             queue_full;
	logic             head_valid;
	ecfe_item_t       push_item;
	ecfe_item_t       head_item;

	// register port: one word, polynomial in the low byte
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CRC_POLY);
	assign prdata = (paddr[2] == REG_CRC_POLY) ? {24'h000000, crc_poly_q} : 32'h00000000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_poly_q <= CRC_POLY_RESET;
		end else if (cfg_wr) begin
			crc_poly_q <= pwdata[7:0];
		end
	end

	// front: takes a byte, updates the crc and classifies escapes
	ecfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.crc_poly   (crc_poly_q),
		.queue_full (queue_full),
		.push       (push),
		.push_item  (push_item)
	);

	// short queue so the front keeps taking bytes while escapes drain
	ecfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	// back: sequences escape, byte, crc and terminator words onto the wire
	ecfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.frame_end  (frame_end),
		.run_last   (run_last)
	);

endmodule
